// ===== hdl/bhc_pkg.sv =====
// shared constants and the byte classifier for the byte histogram
package bhc_pkg;

	localparam int BYTE_BITS  = 8;
	localparam int NUM_BINS   = 1 << BYTE_BITS;
	localparam int CLASS_BITS = 3;
	localparam int NUM_CLASS  = 6;
	localparam int OUT_BITS   = 32;

	typedef logic [BYTE_BITS-1:0]  byte_t;
	typedef logic [CLASS_BITS-1:0] class_t;
	typedef logic [OUT_BITS-1:0]   count_out_t;

	localparam class_t CLS_CONTROL = 3'd0;
	localparam class_t CLS_SPACE   = 3'd1;
	localparam class_t CLS_DIGIT   = 3'd2;
	localparam class_t CLS_LETTER  = 3'd3;
	localparam class_t CLS_GRAPHIC = 3'd4;
	localparam class_t CLS_HIGH    = 3'd5;

	localparam logic MODE_COUNT = 1'b0;
	localparam logic MODE_READ  = 1'b1;

	function automatic class_t class_of(input byte_t b);
		class_t c;
		if (b < 8'd32) begin
			c = CLS_CONTROL;
		end else if (b == 8'd32) begin
			c = CLS_SPACE;
		end else if (b >= 8'd48 && b <= 8'd57) begin
			c = CLS_DIGIT;
		end else if ((b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122)) begin
			c = CLS_LETTER;
		end else if (b <= 8'd127) begin
			c = CLS_GRAPHIC;
		end else begin
			c = CLS_HIGH;
		end
		return c;
	endfunction

endpackage

// ===== hdl/bhc_item_if.sv =====
// input channel: mode and byte
interface bhc_item_if;
	logic                  valid;
	logic                  ready;
	logic                  mode;
	logic [7:0]            byte_value;

	modport source (output valid, output mode, output byte_value, input ready);
	modport sink   (input valid, input mode, input byte_value, output ready);
endinterface

// ===== hdl/bhc_result_if.sv =====
// output channel: addressed bin, class and all totals
interface bhc_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] bin_count;
	logic [2:0]  byte_class;
	logic [31:0] bytes_total;
	logic [31:0] control_total;
	logic [31:0] space_total;
	logic [31:0] digit_total;
	logic [31:0] letter_total;
	logic [31:0] graphic_total;
	logic [31:0] high_total;

	modport source (output valid, output bin_count, output byte_class, output bytes_total,
		output control_total, output space_total, output digit_total, output letter_total,
		output graphic_total, output high_total, input ready);
	modport sink (input valid, input bin_count, input byte_class, input bytes_total,
		input control_total, input space_total, input digit_total, input letter_total,
		input graphic_total, input high_total, output ready);
endinterface

// ===== hdl/byte_histogram_with_class_totals.sv =====
// top level: byte histogram with class totals
//
//  channel  dir  contents
//  item     in   mode, byte_value
//  result   out  bin_count, byte_class, bytes_total and six class totals
//
// one word per cycle unless the result stalls. the bin memory is read in the
// accept cycle; increment and write-back happen as the word leaves the middle
// stage, when the result register loads. back-to-back hits on one bin are served
// by a bypass in the memory. reset clears the totals and per-bin valid bits at
// once, no clearing pass; a stalled result holds the middle stage and the input.
module byte_histogram_with_class_totals #(
	parameter int COUNT_BITS = 32
) (
	input logic         clk,
	input logic         arst_n,
	bhc_item_if.sink    item,
	bhc_result_if.source result
);
	import bhc_pkg::*;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	// middle stage: memory read in flight
	logic   vld_s1;
	logic   mode_s1;
	byte_t  byte_s1;

	logic                                 accept;
	logic                                 adv_s1;
	logic                                 wr_en;
	logic [COUNT_BITS-1:0]                old_cnt;
	logic [COUNT_BITS-1:0]                new_cnt;
	class_t                               cls_s1;
	logic [COUNT_BITS-1:0]                nxt_total;
	logic [NUM_CLASS-1:0][COUNT_BITS-1:0] nxt_class;

	// result register
	logic        out_vld_q;
	count_out_t  bin_q;
	class_t      cls_q;
	count_out_t  total_q;
	count_out_t  ctl_q;
	count_out_t  spc_q;
	count_out_t  dig_q;
	count_out_t  let_q;
	count_out_t  gra_q;
	count_out_t  hi_q;

	// middle stage moves when the result register is free or being drained
	assign adv_s1     = !out_vld_q || result.ready;
	assign item.ready = !vld_s1 || adv_s1;
	assign accept     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item.ready) begin
			vld_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= item.mode;
			byte_s1 <= item.byte_value;
		end
	end

	// saturating bin update, written back as the word leaves the middle stage
	assign cls_s1  = class_of(byte_s1);
	assign wr_en   = vld_s1 && adv_s1 && (mode_s1 == MODE_COUNT);
	assign new_cnt = (mode_s1 == MODE_COUNT && old_cnt != CNT_MAX) ?
		old_cnt + COUNT_BITS'(1) : old_cnt;

	bhc_bin_mem #(
		.COUNT_BITS(COUNT_BITS)
	) u_bin_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (item.byte_value),
		.wr_en   (wr_en),
		.wr_addr (byte_s1),
		.wr_data (new_cnt),
		.rd_data (old_cnt)
	);

	bhc_totals #(
		.COUNT_BITS(COUNT_BITS)
	) u_totals (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd_en    (wr_en),
		.upd_class (cls_s1),
		.nxt_total (nxt_total),
		.nxt_class (nxt_class)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1) begin
			out_vld_q <= vld_s1;
		end
	end

	// reported counts are the low 32 bits of each counter
	always_ff @(posedge clk) begin
		if (vld_s1 && adv_s1) begin
			bin_q   <= OUT_BITS'(new_cnt);
			cls_q   <= cls_s1;
			total_q <= OUT_BITS'(nxt_total);
			ctl_q   <= OUT_BITS'(nxt_class[CLS_CONTROL]);
			spc_q   <= OUT_BITS'(nxt_class[CLS_SPACE]);
			dig_q   <= OUT_BITS'(nxt_class[CLS_DIGIT]);
			let_q   <= OUT_BITS'(nxt_class[CLS_LETTER]);
			gra_q   <= OUT_BITS'(nxt_class[CLS_GRAPHIC]);
			hi_q    <= OUT_BITS'(nxt_class[CLS_HIGH]);
		end
	end

	assign result.valid         = out_vld_q;
	assign result.bin_count     = bin_q;
	assign result.byte_class    = cls_q;
	assign result.bytes_total   = total_q;
	assign result.control_total = ctl_q;
	assign result.space_total   = spc_q;
	assign result.digit_total   = dig_q;
	assign result.letter_total  = let_q;
	assign result.graphic_total = gra_q;
	assign result.high_total    = hi_q;

endmodule

// ===== hdl/bhc_bin_mem.sv =====
// 256-bin count memory with per-entry valid bits and write-to-read forwarding
module bhc_bin_mem #(
	parameter int COUNT_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  bhc_pkg::byte_t        rd_addr,
	input  logic                  wr_en,
	input  bhc_pkg::byte_t        wr_addr,
	input  logic [COUNT_BITS-1:0] wr_data,
	output logic [COUNT_BITS-1:0] rd_data
);
	import bhc_pkg::*;

	logic [COUNT_BITS-1:0] mem [NUM_BINS];
	logic [NUM_BINS-1:0]   vld_q;
	logic [COUNT_BITS-1:0] mem_rd_q;
	logic [COUNT_BITS-1:0] fwd_data_q;
	logic                  fwd_hit_q;
	logic                  ent_vld_q;

	// memory array, no reset
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	// bypass when the entry being read is written at the same edge
	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_hit_q  <= wr_en && (wr_addr == rd_addr);
			fwd_data_q <= wr_data;
		end
	end

	// valid bits: an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			ent_vld_q <= 1'b0;
		end else begin
			if (rd_en) begin
				ent_vld_q <= vld_q[rd_addr];
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_comb begin
		if (fwd_hit_q) begin
			rd_data = fwd_data_q;
		end else if (ent_vld_q) begin
			rd_data = mem_rd_q;
		end else begin
			rd_data = '0;
		end
	end

endmodule

// ===== hdl/bhc_totals.sv =====
// running byte total and the six class totals, saturating
module bhc_totals #(
	parameter int COUNT_BITS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  upd_en,
	input  bhc_pkg::class_t                       upd_class,
	output logic [COUNT_BITS-1:0]                 nxt_total,
	output logic [bhc_pkg::NUM_CLASS-1:0][COUNT_BITS-1:0] nxt_class
);
	import bhc_pkg::*;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	logic [COUNT_BITS-1:0]                total_q;
	logic [NUM_CLASS-1:0][COUNT_BITS-1:0] class_q;

	always_comb begin
		nxt_total = total_q;
		nxt_class = class_q;
		if (upd_en) begin
			if (total_q != CNT_MAX) begin
				nxt_total = total_q + COUNT_BITS'(1);
			end
			for (int k = 0; k < NUM_CLASS; k++) begin
				if (upd_class == CLASS_BITS'(k) && class_q[k] != CNT_MAX) begin
					nxt_class[k] = class_q[k] + COUNT_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			class_q <= '0;
		end else begin
			total_q <= nxt_total;
			class_q <= nxt_class;
		end
	end

endmodule
